>>> hw/rtl/ile_pkg.sv
// Shared types and constants for the indexed list engine.
// Depends on nothing; every other file in hw/rtl imports it.
package ile_pkg;

    localparam int OP_W  = 3;
    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int ST_W  = 3;

    // request operations
    localparam logic [OP_W-1:0] OP_ADD_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD_AT    = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_REM_BACK  = 3'd4;
    localparam logic [OP_W-1:0] OP_REM_AT    = 3'd5;
    localparam logic [OP_W-1:0] OP_GET       = 3'd6;
    localparam logic [OP_W-1:0] OP_FIND      = 3'd7;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [ST_W-1:0] ST_RANGE    = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;   // open a slot at pos and load the new item there
        logic shl;   // cells at or above pos take their right neighbor
    } t_cell_cmd;

endpackage

>>> hw/rtl/ile_if.sv
// Request and response channel interfaces for the indexed list engine.
// Depends on ile_pkg for field widths.
interface ile_in_if;
    import ile_pkg::*;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] item_value;

    modport source (output valid, operation, position, item_value, input ready);
    modport sink   (input valid, operation, position, item_value, output ready);
endinterface

interface ile_out_if;
    import ile_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [ST_W-1:0]         status;
    logic [VAL_W-1:0]        read_value;
    logic signed [POS_W-1:0] found_index;
    logic [POS_W-1:0]        list_length;

    modport source (output valid, status, read_value, found_index, list_length,
                    input ready);
    modport sink   (input valid, status, read_value, found_index, list_length,
                    output ready);
endinterface

>>> hw/rtl/ile_cell.sv
// One storage cell of the list chain: holds a single entry.
// Depends on ile_pkg (t_cell_cmd); instantiated by indexed_list_engine.
module ile_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7,
    parameter int DW  = 32
) (
    input  logic                i_clk,
    input  ile_pkg::t_cell_cmd  i_cmd,
    input  logic [CW-1:0]       i_pos,
    input  logic [DW-1:0]       i_new,
    input  logic [DW-1:0]       i_left,
    input  logic [DW-1:0]       i_right,
    output logic [DW-1:0]       o_q
);
    import ile_pkg::*;

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [DW-1:0] r_q;
    logic [DW-1:0] n_q;

    always_comb begin
        n_q = r_q;
        if (i_cmd.ins) begin
            if (MY_IDX > i_pos) begin
                n_q = i_left;
            end else if (MY_IDX == i_pos) begin
                n_q = i_new;
            end
        end else if (i_cmd.shl) begin
            if (MY_IDX >= i_pos) begin
                n_q = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

>>> hw/rtl/indexed_list_engine.sv
// Ordered list of up to CAPACITY items held in a row of cells, one entry per
// cell. Inserts and removes shift the affected cells together; they (and every
// request that fails a status check) have their result in the output register
// in the cycle after they are accepted. A get or find that passes its status
// checks rotates the whole cell row once through cell 0 in S_SCAN, comparing
// as it goes, then S_FIN loads the result into the output register once it is
// free. Requests are taken one at a time; a new request is accepted only when
// the output register is empty or its result leaves in the same cycle.
// Depends on ile_pkg, ile_if and ile_cell.
module indexed_list_engine #(
    parameter int CAPACITY   = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ile_in_if.sink      i_req,
    ile_out_if.source   o_rsp
);
    import ile_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int WW = (CW > POS_W) ? CW : POS_W;
    localparam int DW = (ITEM_WIDTH < VAL_W) ? ITEM_WIDTH : VAL_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);
    localparam logic [IW-1:0] LAST_K   = IW'(CAPACITY - 1);

    // control
    logic [1:0]       r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [IW-1:0]    r_k, n_k;
    logic             r_found, n_found;
    logic             r_ovld, n_ovld;
    // payload
    logic [OP_W-1:0]  r_op, n_op;
    logic [WW-1:0]    r_pos, n_pos;
    logic [DW-1:0]    r_val, n_val;
    logic [IW-1:0]    r_fidx, n_fidx;
    logic [DW-1:0]    r_rd, n_rd;
    logic [ST_W-1:0]  r_ost, n_ost;
    logic [VAL_W-1:0] r_ord, n_ord;
    logic [POS_W-1:0] r_ofi, n_ofi;
    logic [POS_W-1:0] r_olen, n_olen;

    logic             w_free, w_acc;
    logic [DW-1:0]    w_val;
    logic [WW-1:0]    w_cnt, w_rpos, d_pos;
    logic [ST_W-1:0]  d_st;
    logic             d_ins, d_del, d_scan;
    t_cell_cmd        w_cmd;
    logic [CW-1:0]    w_cpos;
    logic [DW-1:0]    w_q [CAPACITY];

    assign w_free      = !r_ovld || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && w_free;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_val       = i_req.item_value[DW-1:0];
    assign w_cnt       = WW'(r_count);
    assign w_rpos      = WW'(i_req.position);

    // request decode and status checks against the current length
    always_comb begin
        d_st   = ST_OK;
        d_ins  = 1'b0;
        d_del  = 1'b0;
        d_scan = 1'b0;
        d_pos  = '0;
        unique case (i_req.operation) inside
            OP_ADD_FRONT, OP_ADD_BACK, OP_ADD_AT: begin
                if (i_req.operation == OP_ADD_BACK) begin
                    d_pos = w_cnt;
                end else if (i_req.operation == OP_ADD_AT) begin
                    d_pos = w_rpos;
                end
                if (d_pos > w_cnt) begin
                    d_st = ST_RANGE;
                end else if (r_count == FULL_CNT) begin
                    d_st = ST_FULL;
                end else begin
                    d_ins = 1'b1;
                end
            end
            OP_REM_FRONT, OP_REM_BACK, OP_REM_AT: begin
                if (i_req.operation == OP_REM_BACK) begin
                    d_pos = w_cnt - WW'(1);
                end else if (i_req.operation == OP_REM_AT) begin
                    d_pos = w_rpos;
                end
                if (r_count == '0) begin
                    d_st = ST_EMPTY;
                end else if (d_pos >= w_cnt) begin
                    d_st = ST_RANGE;
                end else begin
                    d_del = 1'b1;
                end
            end
            OP_GET: begin
                d_pos = w_rpos;
                if (r_count == '0) begin
                    d_st = ST_EMPTY;
                end else if (d_pos >= w_cnt) begin
                    d_st = ST_RANGE;
                end else begin
                    d_scan = 1'b1;
                end
            end
            default: begin
                if (r_count == '0) begin
                    d_st = ST_EMPTY;
                end else begin
                    d_scan = 1'b1;
                end
            end
        endcase
    end

    // broadcast to the chain: rotate left while scanning
    always_comb begin
        w_cmd.ins = 1'b0;
        w_cmd.shl = 1'b0;
        w_cpos    = '0;
        if (r_state == S_SCAN) begin
            w_cmd.shl = 1'b1;
        end else if (w_acc) begin
            w_cmd.ins = d_ins;
            w_cmd.shl = d_del;
            w_cpos    = d_pos[CW-1:0];
        end
    end

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic [DW-1:0] w_left;
        logic [DW-1:0] w_right;
        if (gi == 0) begin : g_first
            assign w_left = w_val;
        end else begin : g_mid_l
            assign w_left = w_q[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_last
            assign w_right = w_q[0];
        end else begin : g_mid_r
            assign w_right = w_q[gi+1];
        end
        ile_cell #(
            .IDX (gi),
            .CW  (CW),
            .DW  (DW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_pos   (w_cpos),
            .i_new   (w_val),
            .i_left  (w_left),
            .i_right (w_right),
            .o_q     (w_q[gi])
        );
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_k     = r_k;
        n_found = r_found;
        n_ovld  = r_ovld && !o_rsp.ready;
        n_op    = r_op;
        n_pos   = r_pos;
        n_val   = r_val;
        n_fidx  = r_fidx;
        n_rd    = r_rd;
        n_ost   = r_ost;
        n_ord   = r_ord;
        n_ofi   = r_ofi;
        n_olen  = r_olen;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (d_ins) begin
                        n_count = r_count + CW'(1);
                    end else if (d_del) begin
                        n_count = r_count - CW'(1);
                    end
                    if (d_scan) begin
                        n_state = S_SCAN;
                        n_k     = '0;
                        n_found = 1'b0;
                        n_op    = i_req.operation;
                        n_pos   = d_pos;
                        n_val   = w_val;
                    end else begin
                        n_ovld = 1'b1;
                        n_ost  = d_st;
                        n_ord  = '0;
                        n_ofi  = '1;
                        n_olen = POS_W'(n_count);
                    end
                end
            end
            S_SCAN: begin
                // cell 0 holds entry r_k during this step
                if (WW'(r_k) == r_pos) begin
                    n_rd = w_q[0];
                end
                if (!r_found && (WW'(r_k) < w_cnt) && (w_q[0] == r_val)) begin
                    n_found = 1'b1;
                    n_fidx  = r_k;
                end
                if (r_k == LAST_K) begin
                    n_state = S_FIN;
                    n_k     = '0;
                end else begin
                    n_k = r_k + IW'(1);
                end
            end
            S_FIN: begin
                if (w_free) begin
                    n_state = S_IDLE;
                    n_ovld  = 1'b1;
                    n_olen  = POS_W'(r_count);
                    if (r_op == OP_FIND) begin
                        n_ost = r_found ? ST_OK : ST_NOTFOUND;
                        n_ord = '0;
                        n_ofi = r_found ? POS_W'(WW'(r_fidx)) : '1;
                    end else begin
                        n_ost = ST_OK;
                        n_ord = VAL_W'(r_rd);
                        n_ofi = '1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_k     <= '0;
            r_found <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_k     <= n_k;
            r_found <= n_found;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_pos  <= n_pos;
        r_val  <= n_val;
        r_fidx <= n_fidx;
        r_rd   <= n_rd;
        r_ost  <= n_ost;
        r_ord  <= n_ord;
        r_ofi  <= n_ofi;
        r_olen <= n_olen;
    end

    assign o_rsp.valid       = r_ovld;
    assign o_rsp.status      = r_ost;
    assign o_rsp.read_value  = r_ord;
    assign o_rsp.found_index = r_ofi;
    assign o_rsp.list_length = r_olen;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("list length above capacity");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (r_count == FULL_CNT) && !d_del) |=> (r_count == $past(r_count)))
        else $error("length changed on a full list without a remove");

    a_scan_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (r_k == '0))
        else $error("rotation did not complete a full turn");

    a_scan_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> (r_count == $past(r_count)))
        else $error("length changed during a scan");
`endif

endmodule

>>> dv/ile_checker.sv
`timescale 1ns / 100ps
// Response checker for the indexed list engine: models the list from accepted
// request transactions and compares every response transaction in order.
// Depends on ile_pkg and the ile_in_if / ile_out_if channel interfaces.
module ile_checker #(
    parameter int CAPACITY   = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ile_in_if    i_req,
    ile_out_if   i_rsp,
    output int   o_err_count,
    output int   o_pending
);
    import ile_pkg::*;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic [VAL_W-1:0]        read_value;
        logic signed [POS_W-1:0] found_index;
        logic [POS_W-1:0]        list_length;
    } t_rsp;

    logic [ITEM_WIDTH-1:0] item_store [CAPACITY];
    int                    n_items;
    t_rsp                  rsp_due [$];
    int                    errs;

    // Apply one request to the list copy and return the response it must produce.
    function automatic t_rsp list_apply(input logic [OP_W-1:0] op,
                                        input logic [POS_W-1:0] pos,
                                        input logic [VAL_W-1:0] val);
        t_rsp                  r;
        int                    p;
        logic [ITEM_WIDTH-1:0] v;
        bit                    hit;
        r.status      = ST_OK;
        r.read_value  = '0;
        r.found_index = '1;
        v             = ITEM_WIDTH'(val);
        hit           = 1'b0;
        case (op)
            OP_ADD_FRONT, OP_ADD_BACK, OP_ADD_AT: begin
                if (op == OP_ADD_FRONT) p = 0;
                else if (op == OP_ADD_BACK) p = n_items;
                else p = int'(pos);
                // range check wins over the full check
                if (p > n_items) begin
                    r.status = ST_RANGE;
                end else if (n_items >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = n_items; i > p; i--) item_store[i] = item_store[i-1];
                    item_store[p] = v;
                    n_items++;
                end
            end
            OP_REM_FRONT, OP_REM_BACK, OP_REM_AT: begin
                if (op == OP_REM_FRONT) p = 0;
                else if (op == OP_REM_BACK) p = (n_items == 0) ? 0 : n_items - 1;
                else p = int'(pos);
                if (n_items == 0) begin
                    r.status = ST_EMPTY;
                end else if (p >= n_items) begin
                    r.status = ST_RANGE;
                end else begin
                    for (int i = p; i + 1 < n_items; i++) item_store[i] = item_store[i+1];
                    n_items--;
                end
            end
            OP_GET: begin
                if (n_items == 0) r.status = ST_EMPTY;
                else if (int'(pos) >= n_items) r.status = ST_RANGE;
                else r.read_value = VAL_W'(item_store[pos]);
            end
            default: begin
                if (n_items == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.status = ST_NOTFOUND;
                    // lowest matching index wins
                    for (int i = 0; i < n_items; i++) begin
                        if (!hit && item_store[i] == v) begin
                            hit           = 1'b1;
                            r.status      = ST_OK;
                            r.found_index = POS_W'(i);
                        end
                    end
                end
            end
        endcase
        r.list_length = POS_W'(n_items);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            errs++;
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp due;
        if (!i_rst_n) begin
            n_items = 0;
            errs    = 0;
            rsp_due.delete();
        end else begin
            // compare before pushing: a response never belongs to a same-edge request
            if (i_rsp.valid && i_rsp.ready) begin
                if (rsp_due.size() == 0) begin
                    $display("%0t: response with no request outstanding: %s %0d",
                             $time, "expected none, actual status", i_rsp.status);
                    errs++;
                end else begin
                    due = rsp_due.pop_front();
                    check_field("status", VAL_W'(due.status), VAL_W'(i_rsp.status));
                    check_field("read_value", due.read_value, i_rsp.read_value);
                    check_field("found_index", VAL_W'(unsigned'(due.found_index)),
                                VAL_W'(unsigned'(i_rsp.found_index)));
                    check_field("list_length", VAL_W'(due.list_length),
                                VAL_W'(i_rsp.list_length));
                end
            end
            if (i_req.valid && i_req.ready)
                rsp_due.push_back(list_apply(i_req.operation, i_req.position,
                                             i_req.item_value));
        end
        o_err_count <= errs;
        o_pending   <= rsp_due.size();
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// Top of the indexed list engine testbench: clock, reset, request stimulus and
// response back-pressure; checking is done by ile_checker beside the DUT.
// Depends on ile_pkg, ile_if, indexed_list_engine and ile_checker.
module tb_top;
    import ile_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int ITEM_WIDTH   = 32;
    localparam int RANDOM_ITEMS = 1400;
    localparam int DRAIN_CYCLES = CAPACITY + 16;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   err_count;
    int   pending;

    ile_in_if  req_if ();
    ile_out_if rsp_if ();

    indexed_list_engine #(
        .CAPACITY   (CAPACITY),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    ile_checker #(
        .CAPACITY   (CAPACITY),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .i_rsp       (rsp_if),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Present one request and hold it until the transaction completes.
    task automatic send_req(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic [VAL_W-1:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.operation  <= op;
        req_if.position   <= pos;
        req_if.item_value <= val;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // A small pool (so finds hit) and full-range values in equal parts, plus both extremes.
    function automatic logic [VAL_W-1:0] rand_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return VAL_W'($urandom);
        if (r < 90) return 32'hA5C3_0000 | VAL_W'($urandom_range(0, 15));
        if (r < 95) return '0;
        return '1;
    endfunction

    function automatic logic [POS_W-1:0] rand_pos();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return POS_W'($urandom_range(0, 8));
        if (r < 80) return POS_W'($urandom_range(0, CAPACITY));
        return POS_W'($urandom_range(0, 127));
    endfunction

    // Growing segments favor inserts so the list fills; draining ones favor removes.
    function automatic logic [OP_W-1:0] pick_op(input bit grow);
        int r;
        r = $urandom_range(0, 99);
        if (grow) begin
            if (r < 20) return OP_ADD_FRONT;
            if (r < 40) return OP_ADD_BACK;
            if (r < 62) return OP_ADD_AT;
            if (r < 67) return OP_REM_FRONT;
            if (r < 71) return OP_REM_BACK;
            if (r < 75) return OP_REM_AT;
            if (r < 87) return OP_GET;
            return OP_FIND;
        end
        if (r < 4)  return OP_ADD_FRONT;
        if (r < 8)  return OP_ADD_BACK;
        if (r < 12) return OP_ADD_AT;
        if (r < 33) return OP_REM_FRONT;
        if (r < 54) return OP_REM_BACK;
        if (r < 75) return OP_REM_AT;
        if (r < 87) return OP_GET;
        return OP_FIND;
    endfunction

    initial begin
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.operation  = OP_ADD_FRONT;
        req_if.position   = '0;
        req_if.item_value = '0;
        rsp_if.ready      = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 13;
        recv_stall_pct <= 13;

        // empty list: every remove, get and find
        send_req(OP_REM_FRONT, 7'd0, '0);
        send_req(OP_REM_BACK, 7'd0, '0);
        send_req(OP_REM_AT, 7'd0, '0);
        send_req(OP_GET, 7'd0, '0);
        send_req(OP_FIND, 7'd0, '0);
        // insert past the end
        send_req(OP_ADD_AT, 7'd1, 32'h0000_0001);
        send_req(OP_ADD_AT, 7'd64, 32'h0000_0002);
        // build [8000_0001, FFFF_FFFF, 0, FFFF_FFFF, 5555_AAAA]
        send_req(OP_ADD_AT, 7'd0, 32'h0000_0000);
        send_req(OP_ADD_BACK, 7'd0, 32'hFFFF_FFFF);
        send_req(OP_ADD_FRONT, 7'd127, 32'h8000_0001);
        send_req(OP_ADD_AT, 7'd3, 32'h5555_AAAA);
        send_req(OP_ADD_AT, 7'd1, 32'hFFFF_FFFF);
        // find returns the first of two matches; then a miss
        send_req(OP_FIND, 7'd0, 32'hFFFF_FFFF);
        send_req(OP_FIND, 7'd0, 32'h1234_5678);
        send_req(OP_GET, 7'd4, '0);
        send_req(OP_GET, 7'd5, '0);
        send_req(OP_GET, 7'd127, '0);
        send_req(OP_REM_AT, 7'd5, '0);
        send_req(OP_REM_AT, 7'd127, '0);
        send_req(OP_REM_AT, 7'd1, '0);
        send_req(OP_REM_BACK, 7'd0, '0);
        send_req(OP_REM_FRONT, 7'd0, '0);
        send_req(OP_GET, 7'd0, '0);
        send_req(OP_FIND, 7'd0, 32'h0000_0000);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                case ((n / 100) % 4)
                    0: begin
                        send_idle_pct = 0;
                        recv_stall_pct <= 0;
                    end
                    1: begin
                        send_idle_pct = 63;
                        recv_stall_pct <= 0;
                    end
                    2: begin
                        send_idle_pct = 0;
                        recv_stall_pct <= 63;
                    end
                    default: begin
                        send_idle_pct = 13;
                        recv_stall_pct <= 13;
                    end
                endcase
            end
            send_req(pick_op(((n / 160) % 2) == 0), rand_pos(), rand_value());
        end
        req_if.valid <= 1'b0;
        recv_stall_pct <= 0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/ile_pkg.sv
hw/rtl/ile_if.sv
hw/rtl/ile_cell.sv
hw/rtl/indexed_list_engine.sv
dv/ile_checker.sv
dv/tb_top.sv
